// File: rtl/rss_pkg.sv
// Shared constants, types and table functions for the rotated square sprite setup.
package rss_pkg;

  localparam logic [8:0]  DEG_FULL    = 9'd360;
  localparam logic [8:0]  DEG_HALF    = 9'd180;
  localparam logic [8:0]  DEG_3Q      = 9'd270;
  localparam int          DEG_QUARTER = 90;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam int          POS_FRAC    = 8;
  localparam logic [23:0] COLOR_LOW   = 24'hffffff;
  localparam logic [2:0]  VERTEX_LAST = 3'd5;

  typedef struct packed {
    logic [3:0][31:0] x;
    logic [3:0][31:0] y;
    logic [1:0][17:0] u;
    logic [1:0][17:0] v;
    logic [7:0]       alpha;
  } quad_t;

  // sin of d degrees, d in 0..90, Q30, Taylor series to nine terms
  function automatic logic [63:0] sin_q30(input logic [6:0] d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    x    = (64'(d) * PI_Q30) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // rounded sine magnitude in Q(frac)
  function automatic logic [31:0] sine_mag(input logic [6:0] d, input int frac);
    int          sh;
    logic [63:0] q;
    sh = 30 - frac;
    q  = sin_q30(d);
    return 32'((q + (64'd1 << (sh - 1))) >> sh);
  endfunction

  // corner visited by each vertex: triangles 0-1-2 and 2-3-0
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd3;
      3'd5:    c = 2'd0;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/rss_if.sv
// Request and vertex channel interfaces.
interface rss_req_if #(
  parameter int SIDE_BITS = 10
);
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   angle_deg;
  logic signed [15:0]   center_x;
  logic signed [15:0]   center_y;
  logic [SIDE_BITS-1:0] side_size;
  logic [7:0]           alpha;
  logic [16:0]          tex_u_origin;
  logic [16:0]          tex_v_origin;
  logic [16:0]          tex_span;

  modport source (
    output valid, angle_deg, center_x, center_y, side_size, alpha,
           tex_u_origin, tex_v_origin, tex_span,
    input  ready
  );
  modport sink (
    input  valid, angle_deg, center_x, center_y, side_size, alpha,
           tex_u_origin, tex_v_origin, tex_span,
    output ready
  );
endinterface

interface rss_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic [17:0]        vertex_u;
  logic [17:0]        vertex_v;
  logic [31:0]        vertex_color;
  logic               last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, vertex_u, vertex_v, vertex_color, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, vertex_u, vertex_v, vertex_color, last_vertex,
    output ready
  );
endinterface

// File: rtl/rotated_square_sprite_setup.sv
// Top level: rotated square sprite vertex setup with six-vertex output sequencer.
//
// Usage:
//   req  (sink)   one transaction per sprite: angle, center, side, alpha, texture
//                 origin and span.
//   vtx  (source) six transactions per sprite, triangles 0-1-2 and 2-3-0, with
//                 last_vertex set on the sixth.
// Path: a request accepted at a clock edge loads the first of six pipeline
//   stages; its quad passes through the other stages into the vertex holding
//   register, which then drives the six vertices on vtx in order.
// Throughput: the single vertex port bounds it, at six transfers per request. The
//   pipeline accepts a request every cycle until it backs up behind the vertex
//   sequencer; up to seven requests can be in flight.
// Reset: clears all valid bits and the sequencer; the sine table is constant
//   logic, so the block takes requests as soon as reset is released.
// Stall: when vtx.ready is low the current vertex holds, the sequencer stops,
//   and backpressure moves stage by stage toward req.ready; nothing is dropped.
module rotated_square_sprite_setup #(
  parameter int SINE_FRAC_BITS = 14,
  parameter int SIDE_BITS      = 10
) (
  input  logic      clk,
  input  logic      rst,
  rss_req_if.sink   req,
  rss_vtx_if.source vtx
);

  rss_pkg::quad_t quad;
  logic           quad_valid;
  logic           quad_ready;

  rss_rotate #(
    .SINE_FRAC_BITS (SINE_FRAC_BITS),
    .SIDE_BITS      (SIDE_BITS)
  ) u_rotate (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .quad       (quad),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready)
  );

  rss_pkg::quad_t held;
  logic           busy;
  logic [2:0]     cnt;
  logic [1:0]     corner;
  logic           is_last;
  logic           vtx_take;

  assign is_last    = (cnt == rss_pkg::VERTEX_LAST);
  assign vtx_take   = busy && vtx.ready;
  assign quad_ready = !busy || (vtx.ready && is_last);
  assign corner     = rss_pkg::corner_of(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (quad_valid && quad_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (vtx_take) begin
      if (is_last) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (quad_valid && quad_ready) held <= quad;
  end

  assign vtx.valid        = busy;
  assign vtx.vertex_x     = held.x[corner];
  assign vtx.vertex_y     = held.y[corner];
  assign vtx.vertex_u     = held.u[corner[0] ^ corner[1]];
  assign vtx.vertex_v     = held.v[corner[1]];
  assign vtx.vertex_color = {held.alpha, rss_pkg::COLOR_LOW};
  assign vtx.last_vertex  = is_last;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= rss_pkg::VERTEX_LAST)
    else $error("vertex counter out of range");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    quad_valid && quad_ready |=> busy && cnt == 3'd0)
    else $error("new quad did not restart the vertex sequence");

  a_step: assert property (@(posedge clk) disable iff (rst)
    vtx_take && !is_last |=> busy && cnt == $past(cnt) + 3'd1)
    else $error("vertex sequence skipped or repeated");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    vtx_take && is_last && !quad_valid |=> !busy)
    else $error("sequencer stayed busy after the last vertex");
`endif

endmodule

// File: rtl/rss_rotate.sv
// Six-stage pipeline: angle reduction, sine lookup, corner products and positions.
module rss_rotate #(
  parameter int SINE_FRAC_BITS = 14,
  parameter int SIDE_BITS      = 10
) (
  input  logic          clk,
  input  logic          rst,
  rss_req_if.sink       req,
  output rss_pkg::quad_t quad,
  output logic          quad_valid,
  input  logic          quad_ready
);

  localparam int MAG_W  = SINE_FRAC_BITS + 1;
  localparam int SIN_W  = SINE_FRAC_BITS + 2;
  localparam int PROD_W = SIN_W + SIDE_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_SH = SINE_FRAC_BITS - rss_pkg::POS_FRAC;

  // angle + 32768 is reduced mod 360; 32768 mod 360 is 8
  localparam logic [23:0] RECIP_45 = 24'd1456;
  localparam logic [12:0] DIV_45   = 13'd45;
  localparam logic [8:0]  OFS_MOD  = 9'd8;

  typedef struct packed {
    logic       neg;
    logic [6:0] base;
  } fold_t;

  function automatic fold_t fold(input logic [8:0] d);
    fold_t f;
    if (d <= 9'(rss_pkg::DEG_QUARTER)) begin
      f.neg  = 1'b0;
      f.base = d[6:0];
    end else if (d <= rss_pkg::DEG_HALF) begin
      f.neg  = 1'b0;
      f.base = 7'(rss_pkg::DEG_HALF - d);
    end else if (d <= rss_pkg::DEG_3Q) begin
      f.neg  = 1'b1;
      f.base = 7'(d - rss_pkg::DEG_HALF);
    end else begin
      f.neg  = 1'b1;
      f.base = 7'(rss_pkg::DEG_FULL - d);
    end
    return f;
  endfunction

  logic [MAG_W-1:0] quarter [rss_pkg::DEG_QUARTER+1];

  for (genvar g = 0; g <= rss_pkg::DEG_QUARTER; g++) begin : g_quarter
    assign quarter[g] = MAG_W'(rss_pkg::sine_mag(7'(g), SINE_FRAC_BITS));
  end

  logic [6:1] vld;
  logic [7:1] rdy;

  assign rdy[7] = quad_ready;
  for (genvar k = 1; k <= 6; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign req.ready  = rdy[1];
  assign quad_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= req.valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: angle mod 360
  logic [15:0] ang_ofs;
  logic [12:0] ang_hi;
  logic [23:0] ang_prod;
  logic [12:0] ang_qm;
  logic [12:0] ang_r0;
  logic [12:0] ang_r;
  logic [8:0]  ang_m;
  logic [8:0]  ang_is;

  always_comb begin
    ang_ofs  = {~req.angle_deg[15], req.angle_deg[14:0]};
    ang_hi   = ang_ofs[15:3];
    ang_prod = 24'(ang_hi) * RECIP_45;
    ang_qm   = 13'(ang_prod[23:16]) * DIV_45;
    ang_r0   = ang_hi - ang_qm;
    ang_r    = (ang_r0 >= DIV_45) ? ang_r0 - DIV_45 : ang_r0;
    ang_m    = {ang_r[5:0], ang_ofs[2:0]};
    ang_is   = (ang_m < OFS_MOD) ? ang_m + (rss_pkg::DEG_FULL - OFS_MOD) : ang_m - OFS_MOD;
  end

  logic [8:0]           s1_is;
  logic signed [15:0]   s1_cx;
  logic signed [15:0]   s1_cy;
  logic [SIDE_BITS-1:0] s1_side;
  logic [7:0]           s1_alpha;
  logic [16:0]          s1_u0;
  logic [16:0]          s1_v0;
  logic [16:0]          s1_span;

  // stage 2: cosine index, quadrant fold, half extents, texture sums
  logic [8:0]                  ic_sum;
  logic [8:0]                  ang_ic;
  logic signed [SIDE_BITS-1:0] half_s;

  always_comb begin
    ic_sum = s1_is + 9'(rss_pkg::DEG_QUARTER);
    ang_ic = (ic_sum >= rss_pkg::DEG_FULL) ? ic_sum - rss_pkg::DEG_FULL : ic_sum;
    half_s = $signed({1'b0, s1_side[SIDE_BITS-1:1]});
  end

  fold_t                       s2_sf;
  fold_t                       s2_cf;
  logic signed [SIDE_BITS-1:0] s2_a;
  logic signed [SIDE_BITS-1:0] s2_b;
  logic signed [15:0]          s2_cx;
  logic signed [15:0]          s2_cy;
  logic [7:0]                  s2_alpha;
  logic [1:0][17:0]            s2_u;
  logic [1:0][17:0]            s2_v;

  // stage 3: table lookup
  logic signed [SIN_W-1:0]     s3_s;
  logic signed [SIN_W-1:0]     s3_c;
  logic signed [SIDE_BITS-1:0] s3_a;
  logic signed [SIDE_BITS-1:0] s3_b;
  logic signed [15:0]          s3_cx;
  logic signed [15:0]          s3_cy;
  logic [7:0]                  s3_alpha;
  logic [1:0][17:0]            s3_u;
  logic [1:0][17:0]            s3_v;

  logic signed [SIN_W-1:0] s_mag;
  logic signed [SIN_W-1:0] c_mag;

  always_comb begin
    s_mag = $signed({1'b0, quarter[s2_sf.base]});
    c_mag = $signed({1'b0, quarter[s2_cf.base]});
  end

  // stage 4: products
  logic signed [PROD_W-1:0] s4_ca;
  logic signed [PROD_W-1:0] s4_cb;
  logic signed [PROD_W-1:0] s4_sa;
  logic signed [PROD_W-1:0] s4_sb;
  logic signed [15:0]       s4_cx;
  logic signed [15:0]       s4_cy;
  logic [7:0]               s4_alpha;
  logic [1:0][17:0]         s4_u;
  logic [1:0][17:0]         s4_v;

  // stage 5: corner offsets
  logic signed [SUM_W-1:0] s5_xo [4];
  logic signed [SUM_W-1:0] s5_yo [4];
  logic signed [15:0]      s5_cx;
  logic signed [15:0]      s5_cy;
  logic [7:0]              s5_alpha;
  logic [1:0][17:0]        s5_u;
  logic [1:0][17:0]        s5_v;

  logic [1:0] cq [4];
  for (genvar q = 0; q < 4; q++) begin : g_cq
    assign cq[q] = 2'(q);
  end

  // stage 6: round to 1/256 pixel and add center
  logic signed [SUM_W-1:0] xr [4];
  logic signed [SUM_W-1:0] yr [4];

  if (RND_SH == 0) begin : g_no_round
    for (genvar q = 0; q < 4; q++) begin : g_q
      assign xr[q] = s5_xo[q];
      assign yr[q] = s5_yo[q];
    end
  end else begin : g_round
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_SH - 1);
    for (genvar q = 0; q < 4; q++) begin : g_q
      assign xr[q] = (s5_xo[q] + RND_HALF) >>> RND_SH;
      assign yr[q] = (s5_yo[q] + RND_HALF) >>> RND_SH;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_is    <= ang_is;
      s1_cx    <= req.center_x;
      s1_cy    <= req.center_y;
      s1_side  <= req.side_size;
      s1_alpha <= req.alpha;
      s1_u0    <= req.tex_u_origin;
      s1_v0    <= req.tex_v_origin;
      s1_span  <= req.tex_span;
    end
    if (rdy[2]) begin
      s2_sf    <= fold(s1_is);
      s2_cf    <= fold(ang_ic);
      s2_a     <= -half_s;
      s2_b     <= half_s - $signed(SIDE_BITS'(1));
      s2_cx    <= s1_cx;
      s2_cy    <= s1_cy;
      s2_alpha <= s1_alpha;
      s2_u[0]  <= 18'(s1_u0);
      s2_u[1]  <= 18'(s1_u0) + 18'(s1_span);
      s2_v[0]  <= 18'(s1_v0);
      s2_v[1]  <= 18'(s1_v0) + 18'(s1_span);
    end
    if (rdy[3]) begin
      s3_s     <= s2_sf.neg ? -s_mag : s_mag;
      s3_c     <= s2_cf.neg ? -c_mag : c_mag;
      s3_a     <= s2_a;
      s3_b     <= s2_b;
      s3_cx    <= s2_cx;
      s3_cy    <= s2_cy;
      s3_alpha <= s2_alpha;
      s3_u     <= s2_u;
      s3_v     <= s2_v;
    end
    if (rdy[4]) begin
      s4_ca    <= s3_c * s3_a;
      s4_cb    <= s3_c * s3_b;
      s4_sa    <= s3_s * s3_a;
      s4_sb    <= s3_s * s3_b;
      s4_cx    <= s3_cx;
      s4_cy    <= s3_cy;
      s4_alpha <= s3_alpha;
      s4_u     <= s3_u;
      s4_v     <= s3_v;
    end
    if (rdy[5]) begin
      // dx is b on corners 1 and 2, dy is b on corners 2 and 3
      for (int q = 0; q < 4; q++) begin
        s5_xo[q] <= ((cq[q][0] ^ cq[q][1]) ? s4_cb : s4_ca) + (cq[q][1] ? s4_sb : s4_sa);
        s5_yo[q] <= (cq[q][1] ? s4_cb : s4_ca) - ((cq[q][0] ^ cq[q][1]) ? s4_sb : s4_sa);
      end
      s5_cx    <= s4_cx;
      s5_cy    <= s4_cy;
      s5_alpha <= s4_alpha;
      s5_u     <= s4_u;
      s5_v     <= s4_v;
    end
    if (rdy[6]) begin
      for (int q = 0; q < 4; q++) begin
        quad.x[q] <= (32'(s5_cx) <<< rss_pkg::POS_FRAC) + 32'(xr[q]);
        quad.y[q] <= (32'(s5_cy) <<< rss_pkg::POS_FRAC) + 32'(yr[q]);
      end
      quad.alpha <= s5_alpha;
      quad.u     <= s5_u;
      quad.v     <= s5_v;
    end
  end

endmodule

// File: tb/rss_checker.sv
// Checker for the rotated square sprite setup: predicts each quad's vertices and compares them.
`timescale 1ns / 1ps

module rss_checker #(
  parameter int SINE_FRAC_BITS = 14,
  parameter int SIDE_BITS      = 10
) (
  input  logic clk,
  input  logic rst,
  rss_req_if   req,
  rss_vtx_if   vtx,
  output int   errors,
  output int   outstanding,
  output int   checked
);

  localparam int ROUND_SH = 30 - SINE_FRAC_BITS;
  localparam int POS_SH   = SINE_FRAC_BITS - rss_pkg::POS_FRAC;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [17:0]        u;
    logic [17:0]        v;
    logic [31:0]        color;
    logic               last_flag;
  } vertex_t;

  int      sin_tab [0:359];
  vertex_t expected_vertices [$];

  // sine of 0..90 degrees in Q30 via truncated Taylor series
  function automatic longint unsigned taylor_q30(int unsigned deg);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned t;
    longint unsigned plus;
    longint unsigned minus;
    ang    = (longint'(deg) * rss_pkg::PI_Q30) / 64'd180;
    ang_sq = (ang * ang) >> 30;
    t      = ang;
    plus   = ang;
    minus  = 0;
    for (int n = 1; n <= 8; n++) begin
      t = ((t * ang_sq) >> 30) / longint'(2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        minus += t;
      end else begin
        plus += t;
      end
    end
    return (plus > minus) ? plus - minus : 64'd0;
  endfunction

  function automatic int sine_deg(int unsigned deg);
    int unsigned     base;
    bit              neg;
    longint unsigned mag;
    if (deg <= 90) begin
      base = deg; neg = 0;
    end else if (deg <= 180) begin
      base = 180 - deg; neg = 0;
    end else if (deg <= 270) begin
      base = deg - 180; neg = 1;
    end else begin
      base = 360 - deg; neg = 1;
    end
    mag = (taylor_q30(base) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    return neg ? -int'(mag) : int'(mag);
  endfunction

  function automatic int wrap_deg(int a);
    int r;
    r = a % 360;
    if (r < 0) r += 360;
    return r;
  endfunction

  // offset rounded half up to 1/256 pixel, added to the center
  function automatic logic signed [31:0] place(longint center, longint off);
    longint r;
    if (POS_SH == 0) begin
      r = off;
    end else begin
      r = (off + (64'sd1 <<< (POS_SH - 1))) >>> POS_SH;
    end
    return 32'(center * 256 + r);
  endfunction

  initial begin
    for (int d = 0; d < 360; d++) sin_tab[d] = sine_deg(d);
  end

  task automatic predict_sprite();
    longint               sn, cs, half, cx, cy;
    longint               dx [4];
    longint               dy [4];
    logic [17:0]          uu [4];
    logic [17:0]          vv [4];
    logic [17:0]          u_end, v_end;
    logic [SIDE_BITS-1:0] side;
    int                   q;
    vertex_t              vt;
    sn    = sin_tab[wrap_deg(int'(req.angle_deg))];
    cs    = sin_tab[wrap_deg(int'(req.angle_deg) + rss_pkg::DEG_QUARTER)];
    side  = req.side_size;
    half  = longint'(side >> 1);
    cx    = longint'(req.center_x);
    cy    = longint'(req.center_y);
    u_end = 18'(req.tex_u_origin) + 18'(req.tex_span);
    v_end = 18'(req.tex_v_origin) + 18'(req.tex_span);
    dx[0] = -half;    dy[0] = -half;    uu[0] = 18'(req.tex_u_origin); vv[0] = 18'(req.tex_v_origin);
    dx[1] = half - 1; dy[1] = -half;    uu[1] = u_end;                 vv[1] = 18'(req.tex_v_origin);
    dx[2] = half - 1; dy[2] = half - 1; uu[2] = u_end;                 vv[2] = v_end;
    dx[3] = -half;    dy[3] = half - 1; uu[3] = 18'(req.tex_u_origin); vv[3] = v_end;
    for (int k = 0; k < 6; k++) begin
      // triangles 0-1-2 and 2-3-0
      q            = (k == 5) ? 0 : ((k < 3) ? k : k - 1);
      vt.x         = place(cx, cs * dx[q] + sn * dy[q]);
      vt.y         = place(cy, cs * dy[q] - sn * dx[q]);
      vt.u         = uu[q];
      vt.v         = vv[q];
      vt.color     = {req.alpha, rss_pkg::COLOR_LOW};
      vt.last_flag = (k == 5);
      expected_vertices.push_back(vt);
    end
  endtask

  task automatic compare_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic check_vertex();
    vertex_t vt;
    if (expected_vertices.size() == 0) begin
      $error("vertex transaction with no sprite pending");
      errors++;
    end else begin
      vt = expected_vertices.pop_front();
      checked++;
      compare_field("vertex_x", longint'(vt.x), longint'(vtx.vertex_x));
      compare_field("vertex_y", longint'(vt.y), longint'(vtx.vertex_y));
      compare_field("vertex_u", longint'(vt.u), longint'(vtx.vertex_u));
      compare_field("vertex_v", longint'(vt.v), longint'(vtx.vertex_v));
      compare_field("vertex_color", longint'(vt.color), longint'(vtx.vertex_color));
      compare_field("last_vertex", longint'(vt.last_flag), longint'(vtx.last_vertex));
    end
  endtask

  initial begin
    errors      = 0;
    outstanding = 0;
    checked     = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (vtx.valid === 1'b1 && vtx.ready === 1'b1) check_vertex();
      if (req.valid === 1'b1 && req.ready === 1'b1) predict_sprite();
      outstanding <= expected_vertices.size();
    end
  end

  final begin
    if (expected_vertices.size() != 0) begin
      $error("%0d predicted vertices never arrived", expected_vertices.size());
    end
  end

endmodule

// File: tb/tb.sv
// Testbench top for the rotated square sprite setup: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int  SIDE_BITS    = 10;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  RANDOM_ITEMS = 140;
  localparam int  DRAIN_CYCLES = 20;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [9:0]         side;
    logic [7:0]         alpha;
    logic [16:0]        u0;
    logic [16:0]        v0;
    logic [16:0]        span;
  } sprite_t;

  logic clk;
  logic rst;
  logic calm;
  int   errors;
  int   outstanding;
  int   checked;
  int   cycles;
  int   sent;
  int   stall_left;
  int   stall_pick;

  rss_req_if #(.SIDE_BITS(SIDE_BITS)) req_ch ();
  rss_vtx_if                          vtx_ch ();

  rotated_square_sprite_setup #(
    .SINE_FRAC_BITS(14),
    .SIDE_BITS     (SIDE_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .vtx(vtx_ch)
  );

  rss_checker #(
    .SINE_FRAC_BITS(14),
    .SIDE_BITS     (SIDE_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .vtx        (vtx_ch),
    .errors     (errors),
    .outstanding(outstanding),
    .checked    (checked)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      vtx_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (calm) begin
      vtx_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      vtx_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      stall_pick = pick_gap();
      vtx_ch.ready <= (stall_pick == 0);
      stall_left   <= (stall_pick == 0) ? 0 : stall_pick - 1;
    end
  end

  function automatic sprite_t mk(int angle, int cx, int cy, int side, int alpha,
                                 int u0, int v0, int span);
    sprite_t s;
    s.angle = 16'(angle);
    s.cx    = 16'(cx);
    s.cy    = 16'(cy);
    s.side  = 10'(side);
    s.alpha = 8'(alpha);
    s.u0    = 17'(u0);
    s.v0    = 17'(v0);
    s.span  = 17'(span);
    return s;
  endfunction

  function automatic sprite_t rand_sprite();
    sprite_t s;
    int      r;
    r = $urandom_range(0, 99);
    s.angle = (r < 50) ? 16'($urandom) : 16'($urandom_range(0, 1440) - 720);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      s.cx = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
      s.cy = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
    end else begin
      s.cx = 16'($urandom);
      s.cy = 16'($urandom);
    end
    r = $urandom_range(0, 99);
    s.side  = (r < 15) ? 10'($urandom_range(0, 3)) : 10'($urandom_range(0, 1023));
    s.alpha = 8'($urandom);
    s.u0    = 17'($urandom_range(0, 65536));
    s.v0    = 17'($urandom_range(0, 65536));
    s.span  = ($urandom_range(0, 9) == 0) ? 17'd65536 : 17'($urandom_range(0, 65536));
    return s;
  endfunction

  // called right after posedge clk; returns once the sprite has been accepted on req
  task automatic send_sprite(sprite_t s);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.angle_deg    <= s.angle;
    req_ch.center_x     <= s.cx;
    req_ch.center_y     <= s.cy;
    req_ch.side_size    <= s.side;
    req_ch.alpha        <= s.alpha;
    req_ch.tex_u_origin <= s.u0;
    req_ch.tex_v_origin <= s.v0;
    req_ch.tex_span     <= s.span;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sent++;
  endtask

  initial begin
    sprite_t directed [$];
    rst                 = 1'b1;
    calm                = 1'b0;
    cycles              = 0;
    sent                = 0;
    stall_left          = 0;
    vtx_ch.ready        = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.angle_deg    = '0;
    req_ch.center_x     = '0;
    req_ch.center_y     = '0;
    req_ch.side_size    = '0;
    req_ch.alpha        = '0;
    req_ch.tex_u_origin = '0;
    req_ch.tex_v_origin = '0;
    req_ch.tex_span     = '0;

    directed.push_back(mk(0, 0, 0, 2, 0, 0, 0, 0));
    directed.push_back(mk(90, 100, -100, 16, 255, 65536, 65536, 65536));
    directed.push_back(mk(180, 0, 0, 1023, 128, 65535, 65535, 65535));
    directed.push_back(mk(270, -5, 7, 64, 1, 0, 65536, 1));
    directed.push_back(mk(359, 12, 12, 33, 2, 1, 0, 65536));
    directed.push_back(mk(360, 0, 0, 40, 4, 100, 200, 300));
    directed.push_back(mk(-1, 3, -3, 100, 8, 0, 0, 65536));
    directed.push_back(mk(-90, 0, 0, 255, 16, 4096, 8192, 16384));
    directed.push_back(mk(-360, 0, 0, 511, 32, 1, 2, 3));
    directed.push_back(mk(32767, 1000, 1000, 512, 64, 65536, 0, 0));
    directed.push_back(mk(-32768, -1000, 2000, 513, 127, 0, 65536, 0));
    directed.push_back(mk(45, 10, 20, 0, 200, 1000, 1000, 500));
    directed.push_back(mk(135, -10, -20, 1, 100, 65536, 65536, 65536));
    directed.push_back(mk(-45, 32767, -32768, 1023, 255, 0, 0, 65536));
    directed.push_back(mk(30, -32768, 32767, 1023, 0, 65536, 65536, 0));
    directed.push_back(mk(60, -1, -1, 682, 8'haa, 65535, 1, 65535));
    directed.push_back(mk(225, 21845, -21846, 341, 8'h55, 43690, 21845, 43690));
    directed.push_back(mk(-180, 32767, 32767, 1022, 255, 65536, 65536, 65536));
    directed.push_back(mk(-270, -32768, -32768, 1023, 0, 0, 0, 0));
    directed.push_back(mk(-32767, 0, 0, 3, 77, 12345, 54321, 11111));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_sprite(directed[i]);

    // blocks of random sprites; every third block runs without idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) calm <= ((n / 20) % 3 == 2);
      send_sprite(rand_sprite());
    end
    req_ch.valid <= 1'b0;
    calm         <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sprites: angle, side, center and texture extremes, then random mixes.",
             sent);
    $display("Checked %0d vertices with random idle gaps and stalls on both channels.",
             checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rss_pkg.sv
rtl/rss_if.sv
rtl/rss_rotate.sv
rtl/rotated_square_sprite_setup.sv
tb/rss_checker.sv
tb/tb.sv
